/* rtl/pns_pkg.sv */
// ----------------------------------------------------------------------------
// pns_pkg
// shared types and constants of the per-channel noise statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package pns_pkg;

    // parameter defaults
    localparam int DEF_CHANNELS   = 1024;
    localparam int DEF_ADC_BITS   = 10;
    localparam int DEF_COUNT_BITS = 24;

    // fixed port widths
    localparam int CHAN_W      = 10;
    localparam int SAMPLE_W    = 10;
    localparam int CNT_OUT_W   = 24;
    localparam int MEAN_W      = 18;
    localparam int RMS_W       = 17;
    localparam int FRAC_BITS   = 8;
    localparam int VAR_SHIFT   = 16;

    // beat modes
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // top level control
    typedef enum logic [1:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_LOOK,
        CTL_CALC
    } t_ctl_state;

    // readout arithmetic engine
    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_MUL_NQ,
        ENG_MUL_SS,
        ENG_SQRT,
        ENG_DIV_MEAN,
        ENG_DIV_RMS
    } t_eng_state;

    // handshake between control and engine
    typedef struct packed {
        logic start;
    } t_eng_req;

    typedef struct packed {
        logic done;
    } t_eng_rsp;

endpackage

`default_nettype wire

/* rtl/pns_engine.sv */
// ----------------------------------------------------------------------------
// pns_engine
// serial multiply, bitwise square root and restoring divide for readout
// ----------------------------------------------------------------------------
`default_nettype none

module pns_engine import pns_pkg::*; #(
    parameter int ADC_BITS   = DEF_ADC_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  t_eng_req                            i_req,
    input  wire [COUNT_BITS-1:0]                i_count,
    input  wire [COUNT_BITS+ADC_BITS-1:0]       i_sum,
    input  wire [COUNT_BITS+2*ADC_BITS-1:0]     i_sqsum,
    output t_eng_rsp                            o_rsp,
    output logic [MEAN_W-1:0]                   o_mean,
    output logic [RMS_W-1:0]                    o_rms
);

    localparam int CB   = COUNT_BITS;
    localparam int SB   = COUNT_BITS + ADC_BITS;
    localparam int QB   = COUNT_BITS + 2 * ADC_BITS;
    localparam int VB   = CB + QB;
    localparam int XB   = VB + VAR_SHIFT;
    localparam int RB   = (XB + 1) / 2;
    localparam int DW   = (SB + FRAC_BITS > RB) ? SB + FRAC_BITS : RB;
    localparam int MAXC = (DW > SB) ? DW : SB;
    localparam int CNTW = $clog2(MAXC) + 1;

    t_eng_state r_state, n_state;

    logic [CB-1:0]     r_n;
    logic [SB-1:0]     r_s;
    logic [VB-1:0]     r_acc;
    logic [VB-1:0]     r_mcand;
    logic [SB-1:0]     r_mplier;
    logic [VB-1:0]     r_p1;
    logic [2*RB-1:0]   r_x;
    logic [RB-1:0]     r_root;
    logic [RB:0]       r_srem;
    logic [DW-1:0]     r_dvd;
    logic [CB-1:0]     r_rem;
    logic [CNTW-1:0]   r_cnt;
    logic [MEAN_W-1:0] r_mean;
    logic [RMS_W-1:0]  r_rms;
    logic              r_done;

    logic [VB-1:0]   acc_step;
    logic [VB-1:0]   var_val;
    logic [RB+2:0]   rem2;
    logic [RB+2:0]   trial;
    logic            sq_ge;
    logic [RB-1:0]   root_step;
    logic [CB:0]     div_shift;
    logic            div_ge;
    logic [DW-1:0]   dvd_step;
    logic            last;

    // shared datapath steps
    always_comb begin
        acc_step  = r_acc + (r_mplier[0] ? r_mcand : '0);
        var_val   = r_p1 - acc_step;
        rem2      = {r_srem, r_x[2*RB-1 -: 2]};
        trial     = (RB+3)'({r_root, 2'b01});
        sq_ge     = rem2 >= trial;
        root_step = {r_root[RB-2:0], sq_ge};
        div_shift = {r_rem, r_dvd[DW-1]};
        div_ge    = div_shift >= {1'b0, r_n};
        dvd_step  = {r_dvd[DW-2:0], div_ge};
        last      = r_cnt == '0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ENG_IDLE:     if (i_req.start) n_state = ENG_MUL_NQ;
            ENG_MUL_NQ:   if (last) n_state = ENG_MUL_SS;
            ENG_MUL_SS:   if (last) n_state = ENG_SQRT;
            ENG_SQRT:     if (last) n_state = ENG_DIV_MEAN;
            ENG_DIV_MEAN: if (last) n_state = ENG_DIV_RMS;
            ENG_DIV_RMS:  if (last) n_state = ENG_IDLE;
            default:      n_state = ENG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ENG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ENG_DIV_RMS) && last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= r_cnt - 1'b1;
        case (r_state)
            ENG_IDLE: begin
                r_n      <= i_count;
                r_s      <= i_sum;
                r_acc    <= '0;
                r_mcand  <= VB'(i_sqsum);
                r_mplier <= SB'(i_count);
                r_cnt    <= CNTW'(CB - 1);
            end
            ENG_MUL_NQ: begin
                r_acc    <= acc_step;
                r_mcand  <= {r_mcand[VB-2:0], 1'b0};
                r_mplier <= r_mplier >> 1;
                if (last) begin
                    r_p1     <= acc_step;
                    r_acc    <= '0;
                    r_mcand  <= VB'(r_s);
                    r_mplier <= r_s;
                    r_cnt    <= CNTW'(SB - 1);
                end
            end
            ENG_MUL_SS: begin
                r_acc    <= acc_step;
                r_mcand  <= {r_mcand[VB-2:0], 1'b0};
                r_mplier <= r_mplier >> 1;
                if (last) begin
                    r_x    <= (2*RB)'({var_val, {VAR_SHIFT{1'b0}}});
                    r_root <= '0;
                    r_srem <= '0;
                    r_cnt  <= CNTW'(RB - 1);
                end
            end
            ENG_SQRT: begin
                // one root bit per step
                r_srem <= sq_ge ? (RB+1)'(rem2 - trial) : (RB+1)'(rem2);
                r_root <= root_step;
                r_x    <= {r_x[2*RB-3:0], 2'b00};
                if (last) begin
                    r_dvd <= DW'({r_s, {FRAC_BITS{1'b0}}});
                    r_rem <= '0;
                    r_cnt <= CNTW'(DW - 1);
                end
            end
            ENG_DIV_MEAN: begin
                r_rem <= div_ge ? CB'(div_shift - {1'b0, r_n}) : CB'(div_shift);
                r_dvd <= dvd_step;
                if (last) begin
                    r_mean <= MEAN_W'(dvd_step);
                    r_dvd  <= DW'(r_root);
                    r_rem  <= '0;
                    r_cnt  <= CNTW'(DW - 1);
                end
            end
            ENG_DIV_RMS: begin
                r_rem <= div_ge ? CB'(div_shift - {1'b0, r_n}) : CB'(div_shift);
                r_dvd <= dvd_step;
                if (last) r_rms <= RMS_W'(dvd_step);
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_mean     = r_mean;
    assign o_rms      = r_rms;

`ifndef ASSERT_OFF
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("engine done longer than one cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == ENG_IDLE)
        else $error("engine done while still working");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ENG_IDLE && i_req.start) |=> r_state == ENG_MUL_NQ)
        else $error("engine did not take start");
`endif

endmodule

`default_nettype wire

/* rtl/per_channel_noise_statistics.sv */
// ----------------------------------------------------------------------------
// per_channel_noise_statistics
// per-channel sample count, mean and rms noise of adc samples
// ----------------------------------------------------------------------------
// After reset the block sweeps its statistics memory to zero, one channel a
// cycle, with busy high. An accumulate beat (mode 0) of an in-range channel
// then reads the channel's entry from the memory's single read port and
// writes the updated count, sum and sum of squares back, or only sets the
// saturation mark once the count is full. A readout beat (mode 1) of a
// channel with samples runs the engine: a bit-serial multiplier forms
// n*sumsq and sum^2, a bitwise square root unit forms the root of the scaled
// variance and a restoring divider, used twice, gives mean and rms. A readout
// of an unseen or out-of-range channel gives a zero result without the
// engine. Each result shows on the o_ ports for one cycle with o_strobe high
// and cannot be held off. start is taken whenever busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_noise_statistics import pns_pkg::*; #(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int ADC_BITS   = DEF_ADC_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire                  i_mode,
    input  wire [CHAN_W-1:0]     i_channel,
    input  wire [SAMPLE_W-1:0]   i_adc_sample,
    output logic                 o_strobe,
    output logic [CHAN_W-1:0]    o_channel_out,
    output logic                 o_seen,
    output logic [CNT_OUT_W-1:0] o_sample_count,
    output logic [MEAN_W-1:0]    o_mean_fixed,
    output logic [RMS_W-1:0]     o_rms_fixed,
    output logic                 o_saturated
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CB = COUNT_BITS;
    localparam int SB = COUNT_BITS + ADC_BITS;
    localparam int QB = COUNT_BITS + 2 * ADC_BITS;
    localparam int WW = 1 + CB + SB + QB;
    localparam int EW = AW + CHAN_W;
    localparam logic [ADC_BITS-1:0] ADC_MAX = '1;

    // one word per channel: saturation mark, count, sum, sum of squares
    logic [WW-1:0] r_mem [CHANNELS];
    logic [WW-1:0] r_rdata;

    t_ctl_state r_state, n_state;

    logic [AW-1:0]       r_clr_addr;
    logic                r_mode;
    logic [AW-1:0]       r_addr;
    logic                r_valid;
    logic [CHAN_W-1:0]   r_chan;
    logic [ADC_BITS-1:0] r_sample;

    logic                r_strobe;
    logic                r_seen;
    logic [CB-1:0]       r_count_out;
    logic [MEAN_W-1:0]   r_mean_out;
    logic [RMS_W-1:0]    r_rms_out;
    logic                r_sat_out;

    logic                accept;
    logic [EW-1:0]       ch_ext;
    logic [AW-1:0]       in_addr;
    logic                in_valid;
    logic [ADC_BITS-1:0] in_sample;

    logic                rd_sat;
    logic [CB-1:0]       rd_count;
    logic [SB-1:0]       rd_sum;
    logic [QB-1:0]       rd_sq;
    logic [2*ADC_BITS-1:0] samp_sq;
    logic                count_full;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WW-1:0]       mem_wdata;

    t_eng_req            eng_req;
    t_eng_rsp            eng_rsp;
    logic [MEAN_W-1:0]   eng_mean;
    logic [RMS_W-1:0]    eng_rms;
    logic                emit_empty;
    logic                emit_calc;

    // input side decode
    always_comb begin
        accept    = start && !busy;
        ch_ext    = EW'(i_channel);
        in_addr   = ch_ext[AW-1:0];
        in_valid  = ch_ext < EW'(CHANNELS);
        // clip samples above the adc range
        in_sample = (32'(i_adc_sample) > 32'(ADC_MAX)) ? ADC_MAX : ADC_BITS'(i_adc_sample);
    end

    // fields of the entry read for the current beat
    always_comb begin
        {rd_sat, rd_count, rd_sum, rd_sq} = r_rdata;
        samp_sq    = r_sample * r_sample;
        count_full = rd_count == '1;
    end

    // memory write port: clearing sweep or accumulate write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rdata;
        if (r_state == CTL_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == CTL_LOOK && r_mode == MODE_ADD && r_valid) begin
            mem_we = 1'b1;
            if (count_full) begin
                mem_wdata = {1'b1, rd_count, rd_sum, rd_sq};
            end else begin
                mem_wdata = {rd_sat, rd_count + 1'b1,
                             rd_sum + SB'(r_sample), rd_sq + QB'(samp_sq)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[in_addr];
    end

    // control
    always_comb begin
        n_state        = r_state;
        eng_req.start  = 1'b0;
        emit_empty     = 1'b0;
        emit_calc      = 1'b0;
        unique case (r_state)
            CTL_CLEAR: begin
                if (r_clr_addr == AW'(CHANNELS - 1)) n_state = CTL_IDLE;
            end
            CTL_IDLE: begin
                if (accept) n_state = CTL_LOOK;
            end
            CTL_LOOK: begin
                if (r_mode == MODE_ADD) begin
                    n_state = CTL_IDLE;
                end else if (r_valid && rd_count != '0) begin
                    eng_req.start = 1'b1;
                    n_state       = CTL_CALC;
                end else begin
                    emit_empty = 1'b1;
                    n_state    = CTL_IDLE;
                end
            end
            CTL_CALC: begin
                if (eng_rsp.done) begin
                    emit_calc = 1'b1;
                    n_state   = CTL_IDLE;
                end
            end
            default: n_state = CTL_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= CTL_CLEAR;
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= r_clr_addr + 1'b1;
            r_strobe   <= emit_empty || emit_calc;
        end
    end

    // beat capture and result registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_addr   <= in_addr;
            r_valid  <= in_valid;
            r_chan   <= i_channel;
            r_sample <= in_sample;
        end
        if (eng_req.start) begin
            r_count_out <= rd_count;
            r_sat_out   <= rd_sat;
        end
        if (emit_empty) begin
            r_seen      <= 1'b0;
            r_count_out <= '0;
            r_mean_out  <= '0;
            r_rms_out   <= '0;
            r_sat_out   <= 1'b0;
        end
        if (emit_calc) begin
            r_seen     <= 1'b1;
            r_mean_out <= eng_mean;
            r_rms_out  <= eng_rms;
        end
    end

    pns_engine #(
        .ADC_BITS   (ADC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (eng_req),
        .i_count (rd_count),
        .i_sum   (rd_sum),
        .i_sqsum (rd_sq),
        .o_rsp   (eng_rsp),
        .o_mean  (eng_mean),
        .o_rms   (eng_rms)
    );

    assign busy           = r_state != CTL_IDLE;
    assign o_strobe       = r_strobe;
    assign o_channel_out  = r_chan;
    assign o_seen         = r_seen;
    assign o_sample_count = CNT_OUT_W'(r_count_out);
    assign o_mean_fixed   = r_mean_out;
    assign o_rms_fixed    = r_rms_out;
    assign o_saturated    = r_sat_out;

`ifndef ASSERT_OFF
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a beat in progress");
    a_unseen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_seen) |-> (o_mean_fixed == '0 && o_rms_fixed == '0
                                   && !o_saturated && o_sample_count == '0))
        else $error("unseen channel with nonzero statistics");
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_rsp.done |-> r_state == CTL_CALC)
        else $error("engine result outside readout");
`endif

endmodule

`default_nettype wire
